### rtl/core/gcab_pkg.sv
// Shared types, constants and helpers for the glyph coverage alpha blender.
// No dependencies; used by every module in rtl/core.
package gcab_pkg;

    localparam int COV_W      = 8;
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int PROD_W     = 16;
    localparam int A5_W       = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int FMT_W      = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    localparam logic [PIX_W-1:0] SPREAD_MASK = 32'h07e0_f81f;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hff;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_RGBA32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_NONE   = 2'd3;  // unknown, pixel passes untouched

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_RED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_GREEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_BLUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_OPACITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

    // per-stage load enables, one bit per pipeline stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // text color as programmed
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] opacity;
        logic [FMT_W-1:0]  fmt;
    } cfg_t;

    // exact x/255 for x below 65280, where the quotient fits in 8 bits
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

### rtl/core/gcab_alpha.sv
// Stages 1 and 2: effective alpha = opacity * coverage / 255, plus 6-bit alpha.
// Depends on gcab_pkg.
module gcab_alpha (
    input  logic                            aclk,
    input  gcab_pkg::stage_en_t             en,
    input  gcab_pkg::cfg_t                  cfg,
    input  logic [gcab_pkg::COV_W-1:0]      coverage,
    input  logic [gcab_pkg::PIX_W-1:0]      background_pixel,
    output logic [gcab_pkg::CHAN_W-1:0]     alpha,
    output logic [gcab_pkg::A5_W-1:0]       alpha5,
    output logic [gcab_pkg::PIX_W-1:0]      bg_out,
    output logic                            wr_out
);

    localparam int PW = gcab_pkg::PROD_W;

    logic [gcab_pkg::PROD_W-1:0] prod1_reg, prod1_next;
    logic [gcab_pkg::PIX_W-1:0]  bg1_reg, bg2_reg;
    logic                        wr1_reg, wr1_next, wr2_reg;
    logic [gcab_pkg::CHAN_W-1:0] a2_reg, a2_next;
    logic [gcab_pkg::A5_W-1:0]   a5_2_reg, a5_2_next;
    logic [gcab_pkg::CHAN_W:0]   a_round;

    assign prod1_next = PW'(cfg.opacity) * PW'(coverage);
    // unknown format or zero coverage: pass through, no write
    assign wr1_next   = (coverage != '0) && (cfg.fmt != gcab_pkg::FMT_NONE);

    assign a2_next    = gcab_pkg::div255(prod1_reg);
    assign a_round    = {1'b0, a2_next} + 9'd4;
    assign a5_2_next  = a_round[8:3];

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod1_reg <= prod1_next;
            bg1_reg   <= background_pixel;
            wr1_reg   <= wr1_next;
        end
        if (en.s2) begin
            a2_reg    <= a2_next;
            a5_2_reg  <= a5_2_next;
            bg2_reg   <= bg1_reg;
            wr2_reg   <= wr1_reg;
        end
    end

    assign alpha  = a2_reg;
    assign alpha5 = a5_2_reg;
    assign bg_out = bg2_reg;
    assign wr_out = wr2_reg;

endmodule

### rtl/core/gcab_mix.sv
// Stages 3 and 4: per-channel products and RGB565 spread multiply, then
// divide by 255 / fold and select the result. Depends on gcab_pkg.
module gcab_mix (
    input  logic                            aclk,
    input  gcab_pkg::stage_en_t             en,
    input  gcab_pkg::cfg_t                  cfg,
    input  logic [gcab_pkg::CHAN_W-1:0]     alpha,
    input  logic [gcab_pkg::A5_W-1:0]       alpha5,
    input  logic [gcab_pkg::PIX_W-1:0]      bg_in,
    input  logic                            wr_in,
    output logic [gcab_pkg::PIX_W-1:0]      blended_pixel,
    output logic                            write_pixel
);

    localparam int W  = gcab_pkg::PIX_W;
    localparam int PW = gcab_pkg::PROD_W;

    // text color in RGB565, spread under the mask; config must stay static while busy, not enforced here
    logic [gcab_pkg::PROD_W-1:0] r31, g63, b31;
    logic [gcab_pkg::CHAN_W-1:0] r5_q, g6_q, b5_q;
    logic [15:0]                 fg565;
    logic [W-1:0]                fg_spread_reg, fg_spread_next;

    assign r31   = PW'(cfg.red)   * PW'(31);
    assign g63   = PW'(cfg.green) * PW'(63);
    assign b31   = PW'(cfg.blue)  * PW'(31);
    assign r5_q  = gcab_pkg::div255(r31);
    assign g6_q  = gcab_pkg::div255(g63);
    assign b5_q  = gcab_pkg::div255(b31);
    assign fg565 = {r5_q[4:0], g6_q[5:0], b5_q[4:0]};
    assign fg_spread_next = {fg565, fg565} & gcab_pkg::SPREAD_MASK;

    // stage 3
    logic [gcab_pkg::CHAN_W-1:0] bg_r, bg_g, bg_b, inv_a;
    logic [gcab_pkg::PROD_W-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic [gcab_pkg::PROD_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [W-1:0]                bsp_next, bsp_reg, diff, dprod_next, dprod_reg;
    logic [W-1:0]                bg3_reg;
    logic                        wr3_reg;

    always_comb begin
        if (cfg.fmt == gcab_pkg::FMT_RGBA32) begin
            bg_r = bg_in[31:24];
            bg_g = bg_in[23:16];
            bg_b = bg_in[15:8];
        end else begin
            bg_r = bg_in[23:16];
            bg_g = bg_in[15:8];
            bg_b = bg_in[7:0];
        end
    end

    assign inv_a      = gcab_pkg::CHAN_MAX - alpha;
    assign sum_r_next = PW'(cfg.red)   * PW'(alpha) + PW'(bg_r) * PW'(inv_a);
    assign sum_g_next = PW'(cfg.green) * PW'(alpha) + PW'(bg_g) * PW'(inv_a);
    assign sum_b_next = PW'(cfg.blue)  * PW'(alpha) + PW'(bg_b) * PW'(inv_a);

    assign bsp_next   = {bg_in[15:0], bg_in[15:0]} & gcab_pkg::SPREAD_MASK;
    assign diff       = fg_spread_reg - bsp_next;
    assign dprod_next = W'(diff * {{(W-gcab_pkg::A5_W){1'b0}}, alpha5});

    // stage 4
    logic [W-1:0] res_next, res565, out_reg;
    logic         wr4_reg;

    assign res565 = ((dprod_reg >> 5) + bsp_reg) & gcab_pkg::SPREAD_MASK;

    always_comb begin
        res_next = bg3_reg;
        if (wr3_reg) begin
            case (cfg.fmt)
                gcab_pkg::FMT_RGBA32: res_next = {gcab_pkg::div255(sum_r_reg),
                                                  gcab_pkg::div255(sum_g_reg),
                                                  gcab_pkg::div255(sum_b_reg),
                                                  gcab_pkg::CHAN_MAX};
                gcab_pkg::FMT_RGB24:  res_next = {8'd0,
                                                  gcab_pkg::div255(sum_r_reg),
                                                  gcab_pkg::div255(sum_g_reg),
                                                  gcab_pkg::div255(sum_b_reg)};
                gcab_pkg::FMT_RGB565: res_next = {16'd0, res565[31:16] | res565[15:0]};
                default:              res_next = bg3_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        fg_spread_reg <= fg_spread_next;
        if (en.s3) begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            bsp_reg   <= bsp_next;
            dprod_reg <= dprod_next;
            bg3_reg   <= bg_in;
            wr3_reg   <= wr_in;
        end
        if (en.s4) begin
            out_reg   <= res_next;
            wr4_reg   <= wr3_reg;
        end
    end

    assign blended_pixel = out_reg;
    assign write_pixel   = wr4_reg;

endmodule

### rtl/core/glyph_coverage_alpha_blender_core.sv
// Top level of the glyph coverage alpha blender: config registers, stream
// handshake and stage valids. Depends on gcab_pkg, gcab_alpha, gcab_mix.
//
//  channel   direction  payload (low bits first)               handshake
//  s_*       in         coverage[7:0], background_pixel[39:8]  s_tvalid/s_tready
//  m_*       out        tdata: blended_pixel; tuser: write     m_tvalid/m_tready
//  cfg_*     in         index 0..4, 8-bit data                 cfg_we
//
// Four register stages: opacity*coverage, /255 alpha, channel products,
// /255 and format select into the output register. One transaction per cycle
// sustained while m_tready is high. Each stage holds its own valid bit and
// loads when empty or when the stage after it moves, so bubbles close up
// and the input flows while a result waits at the output, until stages fill.
// aresetn (synchronous) clears valids and sets config to its reset values.
module glyph_coverage_alpha_blender_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: coverage[7:0], background_pixel[39:8]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gcab_pkg::S_TDATA_W-1:0]     s_tdata,
    // tdata: blended_pixel[31:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gcab_pkg::M_TDATA_W-1:0]     m_tdata,
    // tuser: write_pixel[0]
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [gcab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // ---------------- configuration registers ----------------
    gcab_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                gcab_pkg::REG_TEXT_RED:     cfg_next.red     = cfg_wdata;
                gcab_pkg::REG_TEXT_GREEN:   cfg_next.green   = cfg_wdata;
                gcab_pkg::REG_TEXT_BLUE:    cfg_next.blue    = cfg_wdata;
                gcab_pkg::REG_TEXT_OPACITY: cfg_next.opacity = cfg_wdata;
                gcab_pkg::REG_PIXEL_FORMAT: cfg_next.fmt     = cfg_wdata[1:0];
                default:                    cfg_next = cfg_reg;  // out of range
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red     <= gcab_pkg::CHAN_MAX;
            cfg_reg.green   <= gcab_pkg::CHAN_MAX;
            cfg_reg.blue    <= gcab_pkg::CHAN_MAX;
            cfg_reg.opacity <= gcab_pkg::CHAN_MAX;
            cfg_reg.fmt     <= gcab_pkg::FMT_RGBA32;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- stage valids and flow control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    gcab_pkg::stage_en_t en;

    // a stage can take new data when empty or when its content moves on
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = s_tvalid && rdy1;
    assign en.s2 = v1_reg && rdy2;
    assign en.s3 = v2_reg && rdy3;
    assign en.s4 = v3_reg && rdy4;

    assign v1_next = rdy1 ? s_tvalid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;
    assign v4_next = rdy4 ? v3_reg   : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    // ---------------- datapath ----------------
    logic [gcab_pkg::CHAN_W-1:0] alpha;
    logic [gcab_pkg::A5_W-1:0]   alpha5;
    logic [gcab_pkg::PIX_W-1:0]  bg2;
    logic                        wr2;

    gcab_alpha u_alpha (
        .aclk             (aclk),
        .en               (en),
        .cfg              (cfg_reg),
        .coverage         (s_tdata[7:0]),
        .background_pixel (s_tdata[39:8]),
        .alpha            (alpha),
        .alpha5           (alpha5),
        .bg_out           (bg2),
        .wr_out           (wr2)
    );

    gcab_mix u_mix (
        .aclk          (aclk),
        .en            (en),
        .cfg           (cfg_reg),
        .alpha         (alpha),
        .alpha5        (alpha5),
        .bg_in         (bg2),
        .wr_in         (wr2),
        .blended_pixel (m_tdata),
        .write_pixel   (m_tuser)
    );

endmodule

### test/gcab_blend_checker.sv
// Checker for the glyph coverage alpha blender: predicts each blended pixel and
// compares it with the result stream. Depends on gcab_pkg for widths and codes.
`timescale 1ns / 100ps

module gcab_blend_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [gcab_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gcab_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_we,
    input  logic [gcab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcab_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               errors,
    output int                               pending
);

    localparam int MAX_PRINTS = 20;

    typedef struct packed {
        logic [gcab_pkg::PIX_W-1:0] pixel;
        logic                       write;
    } pixel_result_t;

    gcab_pkg::cfg_t text_cfg;
    pixel_result_t  blended_q[$];
    pixel_result_t  want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (errors < MAX_PRINTS)
            $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, exp_val);
        errors++;
    endtask

    function automatic logic [7:0] mix_channel(input logic [7:0] fg, input logic [7:0] bg,
                                               input int unsigned a);
        int unsigned sum;
        sum = fg * a + bg * (255 - a);
        return 8'(sum / 255);
    endfunction

    // parallel 565 blend: channels spread apart under the mask, wraps at 32 bits
    function automatic logic [15:0] mix_565(input logic [15:0] fg, input logic [15:0] bg,
                                            input int unsigned a);
        logic [31:0] a5;
        logic [31:0] f;
        logic [31:0] b;
        logic [31:0] r;
        a5 = (a + 4) >> 3;
        f  = ({16'h0, fg} | ({16'h0, fg} << 16)) & gcab_pkg::SPREAD_MASK;
        b  = ({16'h0, bg} | ({16'h0, bg} << 16)) & gcab_pkg::SPREAD_MASK;
        r  = f - b;
        r  = r * a5;
        r  = r >> 5;
        r  = r + b;
        r  = r & gcab_pkg::SPREAD_MASK;
        return r[31:16] | r[15:0];
    endfunction

    function automatic pixel_result_t blend_pixel(input logic [7:0] cov,
                                                  input logic [31:0] bg,
                                                  input gcab_pkg::cfg_t c);
        pixel_result_t res;
        int unsigned   a;
        logic [15:0]   fg565;
        res.pixel = bg;
        res.write = 1'b0;
        if (cov != 0) begin
            a = c.opacity * cov / 255;
            fg565 = {5'(c.red * 31 / 255), 6'(c.green * 63 / 255), 5'(c.blue * 31 / 255)};
            case (c.fmt)
                gcab_pkg::FMT_RGBA32: begin
                    res.pixel = {mix_channel(c.red, bg[31:24], a),
                                 mix_channel(c.green, bg[23:16], a),
                                 mix_channel(c.blue, bg[15:8], a), 8'hff};
                    res.write = 1'b1;
                end
                gcab_pkg::FMT_RGB24: begin
                    res.pixel = {8'h00, mix_channel(c.red, bg[23:16], a),
                                 mix_channel(c.green, bg[15:8], a),
                                 mix_channel(c.blue, bg[7:0], a)};
                    res.write = 1'b1;
                end
                gcab_pkg::FMT_RGB565: begin
                    res.pixel = {16'h0000, mix_565(fg565, bg[15:0], a)};
                    res.write = 1'b1;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            text_cfg <= '{red: 8'hff, green: 8'hff, blue: 8'hff, opacity: 8'hff,
                          fmt: gcab_pkg::FMT_RGBA32};
            blended_q.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (blended_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 32'h0);
                end else begin
                    want = blended_q.pop_front();
                    if (m_tdata !== want.pixel)
                        report_mismatch("blended_pixel", m_tdata, want.pixel);
                    if (m_tuser !== want.write)
                        report_mismatch("write_pixel", {31'h0, m_tuser}, {31'h0, want.write});
                end
            end
            if (s_tvalid && s_tready)
                blended_q.push_back(blend_pixel(s_tdata[7:0], s_tdata[39:8], text_cfg));
            if (cfg_we) begin
                case (cfg_index)
                    gcab_pkg::REG_TEXT_RED:     text_cfg.red     <= cfg_wdata;
                    gcab_pkg::REG_TEXT_GREEN:   text_cfg.green   <= cfg_wdata;
                    gcab_pkg::REG_TEXT_BLUE:    text_cfg.blue    <= cfg_wdata;
                    gcab_pkg::REG_TEXT_OPACITY: text_cfg.opacity <= cfg_wdata;
                    gcab_pkg::REG_PIXEL_FORMAT:
                        text_cfg.fmt <= cfg_wdata[gcab_pkg::FMT_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= blended_q.size();
    end

endmodule

### test/glyph_coverage_alpha_blender_core_tb.sv
// Testbench top for glyph_coverage_alpha_blender_core: drives pixel and config
// traffic and gives the verdict. Depends on gcab_pkg and gcab_blend_checker.
`timescale 1ns / 100ps

module glyph_coverage_alpha_blender_core_tb;

    localparam int STALL_LIMIT    = 1000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 8;     // pipeline is 4 deep, output reg included
    localparam int HOLD_CYCLES    = 60;    // long output back-pressure stretch
    localparam int RANDOM_PER_SET = 66;    // ~600 random pixels over 9 settings
    localparam int NUM_SETTINGS   = 9;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [gcab_pkg::S_TDATA_W-1:0]   s_tdata;    // coverage[7:0], background_pixel[39:8]
    logic                             m_tvalid;
    logic                             m_tready;
    logic [gcab_pkg::M_TDATA_W-1:0]   m_tdata;    // blended_pixel[31:0]
    logic                             m_tuser;    // write_pixel[0]
    logic                             cfg_we;
    logic [gcab_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [gcab_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    int errors;
    int pending;

    // idle rates in percent, set per phase by the stimulus
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int quiet_cycles;

    glyph_coverage_alpha_blender_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gcab_blend_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: any accepted transaction on either channel resets the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random tready, plus one long hold on request so the
    // pipeline fills and pushes back on the input.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One pixel transaction. tvalid stays up between back-to-back pixels;
    // it only drops for idle cycles.
    task automatic send_pixel(input logic [7:0] cov, input logic [31:0] bg);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bg, cov};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering, wait for every predicted pixel, then let the pipe settle.
    // The first edge makes the checker's count include the last transaction.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // cfg_we is left high so consecutive writes never drop and re-raise it
    // in one time step; the caller lowers it after the batch.
    task automatic write_reg(input logic [gcab_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_text(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] op,
                                input logic [7:0] fmt_byte);
        // an index past the register file must be dropped by the block
        write_reg(3'(gcab_pkg::REG_PIXEL_FORMAT + 1 + $urandom_range(2)),
                  8'($urandom_range(255)));
        write_reg(gcab_pkg::REG_TEXT_RED, r);
        write_reg(gcab_pkg::REG_TEXT_GREEN, g);
        write_reg(gcab_pkg::REG_TEXT_BLUE, b);
        write_reg(gcab_pkg::REG_TEXT_OPACITY, op);
        write_reg(gcab_pkg::REG_PIXEL_FORMAT, fmt_byte);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Coverage mix: lots of untouched and fully covered pixels, some minimal
    // coverage, the rest anywhere.
    function automatic logic [7:0] pick_coverage();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) return 8'h00;
        if (roll < 30) return 8'hff;
        if (roll < 40) return 8'h01;
        return 8'($urandom_range(255));
    endfunction

    initial begin : stimulus
        logic [7:0] r, g, b, op, fmt_byte;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        tx_idle_pct = 35;
        rx_idle_pct = 57;
        hold_req    = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            // idle schedule: receiver-heavy, then sender-heavy, then none
            if (k < 3) begin
                tx_idle_pct = 35;
                rx_idle_pct = 57;
            end else if (k < 6) begin
                tx_idle_pct = 57;
                rx_idle_pct = 35;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // setting 0 runs on reset values: white, opaque, RGBA32
            if (k > 0) begin
                r        = 8'($urandom_range(255));
                g        = 8'($urandom_range(255));
                b        = 8'($urandom_range(255));
                op       = 8'($urandom_range(255));
                fmt_byte = {6'd0, gcab_pkg::FMT_RGBA32};
                case (k)
                    1: begin
                        r = 8'h00; g = 8'h00; b = 8'h00; op = 8'hff;
                        fmt_byte = {6'd0, gcab_pkg::FMT_RGB24};
                    end
                    2: begin
                        r = 8'hff; g = 8'h00; b = 8'h80; op = 8'h80;
                        fmt_byte = {6'd0, gcab_pkg::FMT_RGB565};
                    end
                    // zero opacity: nonzero coverage still writes, alpha is zero
                    3: op = 8'h00;
                    // opacity 1: alpha is zero except at full coverage
                    4: begin
                        r = 8'h00; g = 8'hff; b = 8'h00; op = 8'h01;
                        fmt_byte = {6'd0, gcab_pkg::FMT_RGB24};
                    end
                    // format code the block must ignore
                    5: fmt_byte = {6'd0, gcab_pkg::FMT_NONE};
                    // upper data bits set: only the low format bits count
                    6: begin
                        op = 8'hff;
                        fmt_byte = {6'h3f, gcab_pkg::FMT_RGB565};
                    end
                    7: fmt_byte = {6'h3f, gcab_pkg::FMT_RGBA32};
                    default: begin
                        r = 8'hff; g = 8'hff; b = 8'hff;
                        fmt_byte = {6'h2a, gcab_pkg::FMT_RGB24};
                    end
                endcase
                drain_pipeline();
                program_text(r, g, b, op, fmt_byte);
            end

            if (k == 6) hold_req = 1'b1;

            // directed corners for this setting
            send_pixel(8'h00, 32'hffff_ffff);
            send_pixel(8'hff, 32'h0000_0000);
            send_pixel(8'h01, 32'hffff_ffff);

            for (int i = 0; i < RANDOM_PER_SET; i++)
                send_pixel(pick_coverage(), $urandom);
        end

        drain_pipeline();
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/core/gcab_pkg.sv
rtl/core/gcab_alpha.sv
rtl/core/gcab_mix.sv
rtl/core/glyph_coverage_alpha_blender_core.sv
test/gcab_blend_checker.sv
test/glyph_coverage_alpha_blender_core_tb.sv
